FILE: rtl/fcpt_pkg.sv
package fcpt_pkg;

  // Angles in degrees Q.6
  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;
  localparam int PITCH_LIMIT  = 5696;
  localparam int ONE_Q14      = 16384;

  // Rotator start value, gain-compensated, scale 2^28
  localparam logic signed [31:0] CORDIC_X0 = 32'sd163008219;
  localparam int CORDIC_STEPS = 16;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_SENSITIVITY = 3'd0;
  localparam logic [2:0] REG_LOOK_ENABLE = 3'd1;
  localparam logic [2:0] REG_UP_X        = 3'd2;
  localparam logic [2:0] REG_UP_Y        = 3'd3;
  localparam logic [2:0] REG_UP_Z        = 3'd4;
  localparam logic [2:0] REG_START_X     = 3'd5;
  localparam logic [2:0] REG_START_Y     = 3'd6;
  localparam logic [2:0] REG_START_Z     = 3'd7;

  // Command and move direction codes
  localparam logic       CMD_POINTER  = 1'b0;
  localparam logic       CMD_MOVE     = 1'b1;
  localparam logic [1:0] DIR_FORWARD  = 2'd0;
  localparam logic [1:0] DIR_BACKWARD = 2'd1;
  localparam logic [1:0] DIR_RIGHT    = 2'd2;
  localparam logic [1:0] DIR_LEFT     = 2'd3;

  typedef struct packed {
    logic               go;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic               go;
    logic signed [15:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
  } cor_rsp_t;

  // Arctangent of 2^-i in degrees Q.16
  function automatic logic [21:0] atan_q16(input logic [3:0] i);
    logic [21:0] r;
    case (i)
      4'd0:    r = 22'd2949120;
      4'd1:    r = 22'd1740966;
      4'd2:    r = 22'd919879;
      4'd3:    r = 22'd466945;
      4'd4:    r = 22'd234379;
      4'd5:    r = 22'd117266;
      4'd6:    r = 22'd58666;
      4'd7:    r = 22'd29335;
      4'd8:    r = 22'd14668;
      4'd9:    r = 22'd7334;
      4'd10:   r = 22'd3667;
      4'd11:   r = 22'd1833;
      4'd12:   r = 22'd917;
      4'd13:   r = 22'd458;
      4'd14:   r = 22'd229;
      4'd15:   r = 22'd115;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

  // Limit to plus or minus one in Q2.14
  function automatic logic signed [15:0] clamp_unit(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd16384) begin
      r = 16'sd16384;
    end else if (v < -32'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/fcpt_mul.sv
// Shift-add multiplier: one bit of the second operand per cycle, signs applied at the end.
module fcpt_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  fcpt_pkg::mul_req_t  req,
  output fcpt_pkg::mul_rsp_t  rsp
);

  logic               busy_r;
  logic               done_r;
  logic               neg_r;
  logic [63:0]        acc_r;
  logic [63:0]        a_sr_r;
  logic [31:0]        b_sr_r;
  logic signed [63:0] p_r;
  logic [31:0]        a_mag;
  logic [31:0]        b_mag;

  assign a_mag = req.a[31] ? 32'(-req.a) : req.a;
  assign b_mag = req.b[31] ? 32'(-req.b) : req.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        acc_r  <= 64'd0;
        a_sr_r <= {32'd0, a_mag};
        b_sr_r <= b_mag;
        neg_r  <= req.a[31] ^ req.b[31];
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (b_sr_r == 32'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          p_r    <= neg_r ? -$signed(acc_r) : $signed(acc_r);
        end else begin
          if (b_sr_r[0]) begin
            acc_r <= acc_r + a_sr_r;
          end
          a_sr_r <= {a_sr_r[62:0], 1'b0};
          b_sr_r <= {1'b0, b_sr_r[31:1]};
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = p_r;

endmodule

FILE: rtl/fcpt_cordic.sv
// Sine and cosine by a rotating CORDIC, one micro-rotation per cycle.
module fcpt_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  fcpt_pkg::cor_req_t  req,
  output fcpt_pkg::cor_rsp_t  rsp
);

  logic signed [16:0] a0, a1, a2, a3;
  logic               fold_neg;
  logic               busy_r;
  logic               rnd_r;
  logic               done_r;
  logic               neg_r;
  logic [3:0]         it_r;
  logic signed [31:0] x_r, y_r;
  logic signed [25:0] z_r;
  logic signed [31:0] xs, ys;
  logic signed [25:0] at;
  logic signed [15:0] cx, cy;
  logic signed [15:0] cos_r, sin_r;

  // Fold the angle into plus or minus a quarter turn
  always_comb begin
    a0 = {req.angle[15], req.angle};
    a1 = (a0 > 17'sd11520) ? a0 - 17'sd23040 : a0;
    a2 = (a1 <= -17'sd11520) ? a1 + 17'sd23040 : a1;
    if (a2 > 17'sd5760) begin
      a3       = a2 - 17'sd11520;
      fold_neg = 1'b1;
    end else if (a2 < -17'sd5760) begin
      a3       = a2 + 17'sd11520;
      fold_neg = 1'b1;
    end else begin
      a3       = a2;
      fold_neg = 1'b0;
    end
  end

  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;
  assign at = $signed({4'd0, fcpt_pkg::atan_q16(it_r)});
  assign cx = fcpt_pkg::clamp_unit((x_r + 32'sd8192) >>> 14);
  assign cy = fcpt_pkg::clamp_unit((y_r + 32'sd8192) >>> 14);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      rnd_r  <= 1'b0;
      if (req.go) begin
        x_r    <= fcpt_pkg::CORDIC_X0;
        y_r    <= 32'sd0;
        z_r    <= {a3[15:0], 10'd0};
        neg_r  <= fold_neg;
        it_r   <= 4'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (z_r >= 26'sd0) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
        it_r <= it_r + 4'd1;
        if (it_r == 4'(fcpt_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          rnd_r  <= 1'b1;
        end
      end else if (rnd_r) begin
        cos_r  <= neg_r ? -cx : cx;
        sin_r  <= neg_r ? -cy : cy;
        done_r <= 1'b1;
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.cos_v = cos_r;
  assign rsp.sin_v = sin_r;

endmodule

FILE: rtl/fly_camera_pose_tracker_core.sv
// Channel  | Ports                                          | Beat taken when
// ---------+------------------------------------------------+--------------------------
// input    | in_command/pointer_x/pointer_y/move_dir/frame_time | in_valid & in_ready
// result   | out_pos_*, out_front_*, out_yaw_out, out_pitch_out | out_valid & out_ready
// config   | cfg_index, cfg_data                            | cfg_we (no wait)
//
// One beat is worked on at a time; in_ready is high only while the sequencer is idle.
// The serial multiplier finishes once its second operand has no set bits left.
// A right or left step takes six cross products, three squares, a 32-step square root
// and three 15-step divisions; a disabled pointer sample goes straight to the output.
// Reset is synchronous and zeroes the position. A finished pose sits in
// the output register while the next beat is taken; a stalled output holds the sequencer.
module fly_camera_pose_tracker_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic [11:0]        in_pointer_x,
  input  logic [11:0]        in_pointer_y,
  input  logic [1:0]         in_move_dir,
  input  logic [15:0]        in_frame_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [15:0] out_front_x,
  output logic signed [15:0] out_front_y,
  output logic signed [15:0] out_front_z,
  output logic [14:0]        out_yaw_out,
  output logic signed [13:0] out_pitch_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_YMUL = 4'd1;   // yaw step product
  localparam logic [3:0] S_WRAP = 4'd2;   // bring yaw into one turn
  localparam logic [3:0] S_PMUL = 4'd3;   // pitch step product
  localparam logic [3:0] S_CYAW = 4'd4;
  localparam logic [3:0] S_CPIT = 4'd5;
  localparam logic [3:0] S_F0   = 4'd6;
  localparam logic [3:0] S_F2   = 4'd7;
  localparam logic [3:0] S_XMUL = 4'd8;   // cross product terms
  localparam logic [3:0] S_SQ   = 4'd9;   // squared length
  localparam logic [3:0] S_ROOT = 4'd10;
  localparam logic [3:0] S_DSET = 4'd11;
  localparam logic [3:0] S_DIV  = 4'd12;
  localparam logic [3:0] S_MOVE = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0]         state_r;
  logic               issue_r;
  logic [2:0]         idx_r;
  logic [4:0]         cnt_r;

  // Configuration and pose
  logic [15:0]        sens_r;
  logic               look_r;
  logic signed [15:0] up_r [3];
  logic signed [31:0] pos_r [3];
  logic signed [15:0] front_r [3];
  logic [14:0]        yaw_r;
  logic signed [13:0] pitch_r;
  logic [11:0]        last_x_r, last_y_r;
  logic               first_r;

  // Working registers
  logic signed [12:0] dx_r, dy_r;
  logic signed [19:0] ang_r;
  logic signed [15:0] cy_r, sy_r, cp_r;
  logic [20:0]        speed_r;
  logic               back_r;
  logic signed [31:0] cx_r [3];
  logic [63:0]        sq_r;
  logic [63:0]        n_r;
  logic [63:0]        res_r;
  logic [45:0]        dsh_r;
  logic [14:0]        q_r;
  logic signed [15:0] v_r [3];

  // Output register
  logic               out_valid_r;
  logic signed [31:0] o_pos_r [3];
  logic signed [15:0] o_front_r [3];
  logic [14:0]        o_yaw_r;
  logic signed [13:0] o_pitch_r;

  fcpt_pkg::mul_req_t mul_req;
  fcpt_pkg::mul_rsp_t mul_rsp;
  fcpt_pkg::cor_req_t cor_req;
  fcpt_pkg::cor_rsp_t cor_rsp;

  logic               in_acc;
  logic [1:0]         k;
  logic signed [63:0] rnd10, rnd14;
  logic signed [63:0] yaw_sum, pitch_sum;
  logic signed [13:0] pitch_lim;
  logic [63:0]        sq_sum;
  logic [63:0]        root_bit, root_try;
  logic               root_ge, div_ge;
  logic [31:0]        c_mag;
  logic [14:0]        q_new;
  logic signed [31:0] step_raw, step_d;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign k        = idx_r[1:0];

  fcpt_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  fcpt_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .rsp   (cor_rsp)
  );

  // Operand selection for the shared units
  always_comb begin
    mul_req.go = issue_r && (state_r inside {S_YMUL, S_PMUL, S_F0, S_F2, S_XMUL, S_SQ,
                                             S_MOVE});
    mul_req.a  = 32'sd0;
    mul_req.b  = 32'sd0;
    case (state_r)
      S_YMUL: begin
        mul_req.a = 32'(dx_r);
        mul_req.b = $signed({16'd0, sens_r});
      end
      S_PMUL: begin
        mul_req.a = 32'(dy_r);
        mul_req.b = $signed({16'd0, sens_r});
      end
      S_F0: begin
        mul_req.a = 32'(cy_r);
        mul_req.b = 32'(cp_r);
      end
      S_F2: begin
        mul_req.a = 32'(sy_r);
        mul_req.b = 32'(cp_r);
      end
      S_XMUL: begin
        case (idx_r)
          3'd0: begin mul_req.a = 32'(front_r[1]); mul_req.b = 32'(up_r[2]); end
          3'd1: begin mul_req.a = 32'(front_r[2]); mul_req.b = 32'(up_r[1]); end
          3'd2: begin mul_req.a = 32'(front_r[2]); mul_req.b = 32'(up_r[0]); end
          3'd3: begin mul_req.a = 32'(front_r[0]); mul_req.b = 32'(up_r[2]); end
          3'd4: begin mul_req.a = 32'(front_r[0]); mul_req.b = 32'(up_r[1]); end
          default: begin mul_req.a = 32'(front_r[1]); mul_req.b = 32'(up_r[0]); end
        endcase
      end
      S_SQ: begin
        mul_req.a = cx_r[k];
        mul_req.b = cx_r[k];
      end
      S_MOVE: begin
        mul_req.a = $signed({11'd0, speed_r});
        mul_req.b = 32'(v_r[k]);
      end
      default: begin
        mul_req.a = 32'sd0;
        mul_req.b = 32'sd0;
      end
    endcase
    cor_req.go    = issue_r && (state_r inside {S_CYAW, S_CPIT});
    cor_req.angle = (state_r == S_CPIT) ? 16'(pitch_r) : $signed({1'b0, yaw_r});
  end

  // Datapath helpers
  always_comb begin
    rnd10     = (mul_rsp.p + 64'sd512) >>> 10;
    rnd14     = (mul_rsp.p + 64'sd8192) >>> 14;
    yaw_sum   = $signed({49'd0, yaw_r}) + rnd10;
    pitch_sum = 64'(pitch_r) + rnd10;
    if (pitch_sum > 64'(fcpt_pkg::PITCH_LIMIT)) begin
      pitch_lim = 14'(fcpt_pkg::PITCH_LIMIT);
    end else if (pitch_sum < -64'(fcpt_pkg::PITCH_LIMIT)) begin
      pitch_lim = -14'(fcpt_pkg::PITCH_LIMIT);
    end else begin
      pitch_lim = pitch_sum[13:0];
    end
    sq_sum   = sq_r + mul_rsp.p;
    root_bit = 64'd1 << {cnt_r, 1'b0};
    root_try = res_r + root_bit;
    root_ge  = (n_r >= root_try);
    div_ge   = (n_r >= {18'd0, dsh_r});
    c_mag    = cx_r[k][31] ? 32'(-cx_r[k]) : cx_r[k];
    q_new    = {q_r[13:0], div_ge};
    step_raw = rnd14[31:0];
    step_d   = back_r ? -step_raw : step_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
      sens_r      <= 16'd6554;
      look_r      <= 1'b1;
      up_r[0]     <= 16'sd0;
      up_r[1]     <= 16'(fcpt_pkg::ONE_Q14);
      up_r[2]     <= 16'sd0;
      pos_r[0]    <= 32'sd0;
      pos_r[1]    <= 32'sd0;
      pos_r[2]    <= 32'sd0;
      front_r[0]  <= 16'(fcpt_pkg::ONE_Q14);
      front_r[1]  <= 16'sd0;
      front_r[2]  <= 16'sd0;
      yaw_r       <= 15'd0;
      pitch_r     <= 14'sd0;
      last_x_r    <= 12'd0;
      last_y_r    <= 12'd0;
      first_r     <= 1'b1;
    end else begin
      issue_r <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Register writes must arrive only while idle; the block itself does not enforce this
      if (cfg_we) begin
        case (cfg_index)
          fcpt_pkg::REG_SENSITIVITY: sens_r   <= cfg_data[15:0];
          fcpt_pkg::REG_LOOK_ENABLE: look_r   <= cfg_data[0];
          fcpt_pkg::REG_UP_X:        up_r[0]  <= cfg_data[15:0];
          fcpt_pkg::REG_UP_Y:        up_r[1]  <= cfg_data[15:0];
          fcpt_pkg::REG_UP_Z:        up_r[2]  <= cfg_data[15:0];
          fcpt_pkg::REG_START_X:     pos_r[0] <= cfg_data;
          fcpt_pkg::REG_START_Y:     pos_r[1] <= cfg_data;
          fcpt_pkg::REG_START_Z:     pos_r[2] <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            idx_r <= 3'd0;
            if (in_command == fcpt_pkg::CMD_POINTER) begin
              if (look_r) begin
                // First sample only seeds the remembered pointer
                if (first_r) begin
                  dx_r <= 13'sd0;
                  dy_r <= 13'sd0;
                end else begin
                  dx_r <= $signed({1'b0, in_pointer_x}) - $signed({1'b0, last_x_r});
                  dy_r <= $signed({1'b0, last_y_r}) - $signed({1'b0, in_pointer_y});
                end
                last_x_r <= in_pointer_x;
                last_y_r <= in_pointer_y;
                first_r  <= 1'b0;
                state_r  <= S_YMUL;
                issue_r  <= 1'b1;
              end else begin
                state_r <= S_FIN;
              end
            end else begin
              // Distance is 30 times the frame time: 32x minus 2x
              speed_r <= {in_frame_time, 5'd0} - {4'd0, in_frame_time, 1'b0};
              back_r  <= in_move_dir inside {fcpt_pkg::DIR_BACKWARD, fcpt_pkg::DIR_LEFT};
              issue_r <= 1'b1;
              if (in_move_dir inside {fcpt_pkg::DIR_FORWARD, fcpt_pkg::DIR_BACKWARD}) begin
                v_r[0]  <= front_r[0];
                v_r[1]  <= front_r[1];
                v_r[2]  <= front_r[2];
                state_r <= S_MOVE;
              end else begin
                state_r <= S_XMUL;
              end
            end
          end
        end

        S_YMUL: begin
          if (mul_rsp.done) begin
            ang_r   <= yaw_sum[19:0];
            state_r <= S_WRAP;
          end
        end

        S_WRAP: begin
          // Subtract or add one turn per cycle until in range
          if (ang_r < 20'sd0) begin
            ang_r <= ang_r + 20'(fcpt_pkg::FULL_TURN);
          end else if (ang_r >= 20'(fcpt_pkg::FULL_TURN)) begin
            ang_r <= ang_r - 20'(fcpt_pkg::FULL_TURN);
          end else begin
            yaw_r   <= ang_r[14:0];
            state_r <= S_PMUL;
            issue_r <= 1'b1;
          end
        end

        S_PMUL: begin
          if (mul_rsp.done) begin
            pitch_r <= pitch_lim;
            state_r <= S_CYAW;
            issue_r <= 1'b1;
          end
        end

        S_CYAW: begin
          if (cor_rsp.done) begin
            cy_r    <= cor_rsp.cos_v;
            sy_r    <= cor_rsp.sin_v;
            state_r <= S_CPIT;
            issue_r <= 1'b1;
          end
        end

        S_CPIT: begin
          if (cor_rsp.done) begin
            cp_r       <= cor_rsp.cos_v;
            front_r[1] <= cor_rsp.sin_v;
            state_r    <= S_F0;
            issue_r    <= 1'b1;
          end
        end

        S_F0: begin
          if (mul_rsp.done) begin
            front_r[0] <= fcpt_pkg::clamp_unit(rnd14[31:0]);
            state_r    <= S_F2;
            issue_r    <= 1'b1;
          end
        end

        S_F2: begin
          if (mul_rsp.done) begin
            front_r[2] <= fcpt_pkg::clamp_unit(rnd14[31:0]);
            state_r    <= S_FIN;
          end
        end

        S_XMUL: begin
          // Even terms load a component, odd terms subtract from it
          if (mul_rsp.done) begin
            if (idx_r[0]) begin
              cx_r[idx_r[2:1]] <= cx_r[idx_r[2:1]] - mul_rsp.p[31:0];
            end else begin
              cx_r[idx_r[2:1]] <= mul_rsp.p[31:0];
            end
            issue_r <= 1'b1;
            if (idx_r == 3'd5) begin
              idx_r   <= 3'd0;
              sq_r    <= 64'd0;
              state_r <= S_SQ;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end

        S_SQ: begin
          if (mul_rsp.done) begin
            sq_r <= sq_sum;
            if (idx_r == 3'd2) begin
              // Zero cross product: leave the position alone
              if (sq_sum == 64'd0) begin
                state_r <= S_FIN;
              end else begin
                n_r     <= sq_sum;
                res_r   <= 64'd0;
                cnt_r   <= 5'd31;
                state_r <= S_ROOT;
              end
            end else begin
              idx_r   <= idx_r + 3'd1;
              issue_r <= 1'b1;
            end
          end
        end

        S_ROOT: begin
          // One result bit per cycle, floor square root
          if (root_ge) begin
            n_r   <= n_r - root_try;
            res_r <= {1'b0, res_r[63:1]} + root_bit;
          end else begin
            res_r <= {1'b0, res_r[63:1]};
          end
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            idx_r   <= 3'd0;
            state_r <= S_DSET;
          end
        end

        S_DSET: begin
          // Numerator |c| * 2^14 plus half the length, rounded quotient
          n_r     <= {18'd0, c_mag, 14'd0} + {1'b0, res_r[63:1]};
          dsh_r   <= {res_r[31:0], 14'd0};
          q_r     <= 15'd0;
          cnt_r   <= 5'd14;
          state_r <= S_DIV;
        end

        S_DIV: begin
          if (div_ge) begin
            n_r <= n_r - {18'd0, dsh_r};
          end
          dsh_r <= {1'b0, dsh_r[45:1]};
          q_r   <= q_new;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            v_r[k] <= cx_r[k][31] ? -$signed({1'b0, q_new}) : $signed({1'b0, q_new});
            if (idx_r == 3'd2) begin
              idx_r   <= 3'd0;
              state_r <= S_MOVE;
              issue_r <= 1'b1;
            end else begin
              idx_r   <= idx_r + 3'd1;
              state_r <= S_DSET;
            end
          end
        end

        S_MOVE: begin
          if (mul_rsp.done) begin
            pos_r[k] <= pos_r[k] + step_d;
            if (idx_r == 3'd2) begin
              state_r <= S_FIN;
            end else begin
              idx_r   <= idx_r + 3'd1;
              issue_r <= 1'b1;
            end
          end
        end

        S_FIN: begin
          // Hold until the output register is free
          if (!out_valid_r || out_ready) begin
            o_pos_r[0]   <= pos_r[0];
            o_pos_r[1]   <= pos_r[1];
            o_pos_r[2]   <= pos_r[2];
            o_front_r[0] <= front_r[0];
            o_front_r[1] <= front_r[1];
            o_front_r[2] <= front_r[2];
            o_yaw_r      <= yaw_r;
            o_pitch_r    <= pitch_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x     = o_pos_r[0];
  assign out_pos_y     = o_pos_r[1];
  assign out_pos_z     = o_pos_r[2];
  assign out_front_x   = o_front_r[0];
  assign out_front_y   = o_front_r[1];
  assign out_front_z   = o_front_r[2];
  assign out_yaw_out   = o_yaw_r;
  assign out_pitch_out = o_pitch_r;

endmodule
